>>> hdl/ibs_pkg.sv
// shared types, constants and defaults of the bilinear image scaler
`default_nettype none

package ibs_pkg;

    localparam int MAX_SRC_WIDTH_DEF  = 256;
    localparam int MAX_SRC_HEIGHT_DEF = 256;
    localparam int MAX_DST_DIM_DEF    = 1024;
    localparam int FRAC_BITS_DEF      = 8;

    localparam int SRC_DIM_W   = 9;
    localparam int DST_DIM_W   = 11;
    localparam int STEP_W      = 24;
    localparam int STEP_FRAC   = 16;
    localparam int COORD_W     = 10;
    localparam int PIX_W       = 8;
    localparam int CFG_DATA_W  = 24;
    localparam int CFG_INDEX_W = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_SRC_WIDTH  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SRC_HEIGHT = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DST_WIDTH  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_DST_HEIGHT = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_X_STEP     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_Y_STEP     = 3'd5;

    localparam logic [SRC_DIM_W-1:0] SRC_DIM_RESET = 9'd256;
    localparam logic [DST_DIM_W-1:0] DST_DIM_RESET = 11'd256;
    localparam logic [STEP_W-1:0]    STEP_RESET    = 24'd65536;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EMIT = 1'b1;

    // neighbour codes: bit 0 selects the right column, bit 1 the lower row
    localparam logic [1:0] NB_TL = 2'd0;
    localparam logic [1:0] NB_TR = 2'd1;
    localparam logic [1:0] NB_BL = 2'd2;
    localparam logic [1:0] NB_BR = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POS,
        ST_LOC,
        ST_RD0,
        ST_RD1,
        ST_RD2,
        ST_RD3,
        ST_FIN
    } ibs_state_t;

    typedef struct packed {
        logic       load;
        logic       pos;
        logic       loc;
        logic       rd;
        logic [1:0] nb;
        logic       acc_load;
        logic       acc_add;
        logic       fin;
    } ibs_ctrl_t;

endpackage

`default_nettype wire

>>> hdl/ibs_ram.sv
// generic single-port ram with registered read
`default_nettype none

module ibs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    addr,
    input  wire logic [WIDTH-1:0] wdata,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

>>> hdl/ibs_ctrl.sv
// sequencing state machine for load and emit commands
`default_nettype none

module ibs_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic          command,
    output logic               busy,
    output ibs_pkg::ibs_ctrl_t ctrl
);

    import ibs_pkg::*;

    ibs_state_t state_reg;
    ibs_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        ctrl          = '0;
        busy          = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start && command == CMD_LOAD)
                begin
                    ctrl.load = 1'b1;
                end
                if (start && command == CMD_EMIT)
                begin
                    state_next = ST_POS;
                end
            end
            ST_POS:
            begin
                ctrl.pos   = 1'b1;
                state_next = ST_LOC;
            end
            ST_LOC:
            begin
                ctrl.loc   = 1'b1;
                state_next = ST_RD0;
            end
            ST_RD0:
            begin
                ctrl.rd    = 1'b1;
                ctrl.nb    = NB_TL;
                state_next = ST_RD1;
            end
            ST_RD1:
            begin
                ctrl.rd       = 1'b1;
                ctrl.nb       = NB_TR;
                ctrl.acc_load = 1'b1;
                state_next    = ST_RD2;
            end
            ST_RD2:
            begin
                ctrl.rd      = 1'b1;
                ctrl.nb      = NB_BL;
                ctrl.acc_add = 1'b1;
                state_next   = ST_RD3;
            end
            ST_RD3:
            begin
                ctrl.rd      = 1'b1;
                ctrl.nb      = NB_BR;
                ctrl.acc_add = 1'b1;
                state_next   = ST_FIN;
            end
            ST_FIN:
            begin
                ctrl.fin   = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hdl/ibs_datapath.sv
// configuration registers, position arithmetic, pixel store and blend
`default_nettype none

module ibs_datapath #(
    parameter int MAX_SRC_WIDTH  = ibs_pkg::MAX_SRC_WIDTH_DEF,
    parameter int MAX_SRC_HEIGHT = ibs_pkg::MAX_SRC_HEIGHT_DEF,
    parameter int MAX_DST_DIM    = ibs_pkg::MAX_DST_DIM_DEF,
    parameter int FRAC_BITS      = ibs_pkg::FRAC_BITS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire ibs_pkg::ibs_ctrl_t                 ctrl,
    input  wire logic [ibs_pkg::PIX_W-1:0]          pixel,
    input  wire logic                               cfg_we,
    input  wire logic [ibs_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [ibs_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                                    done,
    output logic      [ibs_pkg::PIX_W-1:0]          value,
    output logic      [ibs_pkg::COORD_W-1:0]        out_col,
    output logic      [ibs_pkg::COORD_W-1:0]        out_row,
    output logic                                    last_pixel
);

    import ibs_pkg::*;

    localparam int DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int POS_W = COORD_W + STEP_W;
    localparam int IP_W  = POS_W - STEP_FRAC;
    localparam int WGT_W = FRAC_BITS + 1;
    localparam int W2_W  = 2 * WGT_W;
    localparam int ACC_W = W2_W + PIX_W;
    localparam int AREA_W = 2 * SRC_DIM_W;
    localparam logic [WGT_W-1:0] ONE = WGT_W'(1) << FRAC_BITS;

    // configuration
    logic [SRC_DIM_W-1:0] src_width_reg;
    logic [SRC_DIM_W-1:0] src_height_reg;
    logic [DST_DIM_W-1:0] dst_width_reg;
    logic [DST_DIM_W-1:0] dst_height_reg;
    logic [STEP_W-1:0]    x_step_reg;
    logic [STEP_W-1:0]    y_step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= SRC_DIM_RESET;
            src_height_reg <= SRC_DIM_RESET;
            dst_width_reg  <= DST_DIM_RESET;
            dst_height_reg <= DST_DIM_RESET;
            x_step_reg     <= STEP_RESET;
            y_step_reg     <= STEP_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SRC_WIDTH:  src_width_reg  <= cfg_data[SRC_DIM_W-1:0];
                REG_SRC_HEIGHT: src_height_reg <= cfg_data[SRC_DIM_W-1:0];
                REG_DST_WIDTH:  dst_width_reg  <= cfg_data[DST_DIM_W-1:0];
                REG_DST_HEIGHT: dst_height_reg <= cfg_data[DST_DIM_W-1:0];
                REG_X_STEP:     x_step_reg     <= cfg_data[STEP_W-1:0];
                REG_Y_STEP:     y_step_reg     <= cfg_data[STEP_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // effective dimensions: zero acts as one, above maximum acts as maximum
    logic [SRC_DIM_W-1:0] sw;
    logic [SRC_DIM_W-1:0] sh;
    logic [DST_DIM_W-1:0] dw;
    logic [DST_DIM_W-1:0] dh;

    always_comb
    begin
        if (src_width_reg == '0)
            sw = SRC_DIM_W'(1);
        else if (32'(src_width_reg) > MAX_SRC_WIDTH)
            sw = SRC_DIM_W'(MAX_SRC_WIDTH);
        else
            sw = src_width_reg;

        if (src_height_reg == '0)
            sh = SRC_DIM_W'(1);
        else if (32'(src_height_reg) > MAX_SRC_HEIGHT)
            sh = SRC_DIM_W'(MAX_SRC_HEIGHT);
        else
            sh = src_height_reg;

        if (dst_width_reg == '0)
            dw = DST_DIM_W'(1);
        else if (32'(dst_width_reg) > MAX_DST_DIM)
            dw = DST_DIM_W'(MAX_DST_DIM);
        else
            dw = dst_width_reg;

        if (dst_height_reg == '0)
            dh = DST_DIM_W'(1);
        else if (32'(dst_height_reg) > MAX_DST_DIM)
            dh = DST_DIM_W'(MAX_DST_DIM);
        else
            dh = dst_height_reg;
    end

    // load pointer
    logic [AW-1:0]     load_index_reg;
    logic [AREA_W-1:0] area;
    logic [AW:0]       load_inc;

    assign area     = sw * sh;
    assign load_inc = (AW+1)'(load_index_reg) + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_index_reg <= '0;
        end
        else if (ctrl.load)
        begin
            if (32'(load_inc) >= 32'(area))
                load_index_reg <= '0;
            else
                load_index_reg <= load_inc[AW-1:0];
        end
    end

    // source position of the current destination pixel
    logic [COORD_W-1:0] emit_col_reg;
    logic [COORD_W-1:0] emit_row_reg;
    logic [POS_W-1:0]   xpos_reg;
    logic [POS_W-1:0]   ypos_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.pos)
        begin
            xpos_reg <= emit_col_reg * x_step_reg;
            ypos_reg <= emit_row_reg * y_step_reg;
        end
    end

    function automatic logic [SRC_DIM_W-1:0] clamp_idx(
        input logic [IP_W:0]        ip,
        input logic [SRC_DIM_W-1:0] last
    );
        logic [SRC_DIM_W-1:0] r;
        if (ip > (IP_W+1)'(last))
            r = last;
        else
            r = ip[SRC_DIM_W-1:0];
        return r;
    endfunction

    logic [IP_W-1:0]      ipx;
    logic [IP_W-1:0]      ipy;
    logic [SRC_DIM_W-1:0] x_last;
    logic [SRC_DIM_W-1:0] y_last;
    logic [SRC_DIM_W-1:0] y0;
    logic [SRC_DIM_W-1:0] y1;
    logic [AREA_W-1:0]    row0_prod;
    logic [AREA_W-1:0]    row1_prod;

    assign ipx       = xpos_reg[POS_W-1:STEP_FRAC];
    assign ipy       = ypos_reg[POS_W-1:STEP_FRAC];
    assign x_last    = sw - 1'b1;
    assign y_last    = sh - 1'b1;
    assign y0        = clamp_idx((IP_W+1)'(ipy), y_last);
    assign y1        = clamp_idx((IP_W+1)'(ipy) + 1'b1, y_last);
    assign row0_prod = y0 * sw;
    assign row1_prod = y1 * sw;

    logic [SRC_DIM_W-1:0] x0_reg;
    logic [SRC_DIM_W-1:0] x1_reg;
    logic [AW-1:0]        base0_reg;
    logic [AW-1:0]        base1_reg;
    logic [FRAC_BITS-1:0] fx_reg;
    logic [FRAC_BITS-1:0] fy_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.loc)
        begin
            x0_reg    <= clamp_idx((IP_W+1)'(ipx), x_last);
            x1_reg    <= clamp_idx((IP_W+1)'(ipx) + 1'b1, x_last);
            base0_reg <= AW'(row0_prod);
            base1_reg <= AW'(row1_prod);
            fx_reg    <= xpos_reg[STEP_FRAC-1 -: FRAC_BITS];
            fy_reg    <= ypos_reg[STEP_FRAC-1 -: FRAC_BITS];
        end
    end

    // neighbour fetch and weight
    logic [WGT_W-1:0] wx;
    logic [WGT_W-1:0] wy;
    logic [AW-1:0]    rd_addr;
    logic [AW-1:0]    ram_addr;
    logic [W2_W-1:0]  w_reg;
    logic [PIX_W-1:0] rdata;

    assign wx       = ctrl.nb[0] ? WGT_W'(fx_reg) : ONE - WGT_W'(fx_reg);
    assign wy       = ctrl.nb[1] ? WGT_W'(fy_reg) : ONE - WGT_W'(fy_reg);
    assign rd_addr  = (ctrl.nb[1] ? base1_reg : base0_reg)
                    + AW'(ctrl.nb[0] ? x1_reg : x0_reg);
    assign ram_addr = ctrl.load ? load_index_reg : rd_addr;

    always_ff @(posedge clk)
    begin
        if (ctrl.rd)
        begin
            w_reg <= wx * wy;
        end
    end

    ibs_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (ctrl.load),
        .addr  (ram_addr),
        .wdata (pixel),
        .rdata (rdata)
    );

    // weighted sum
    logic [ACC_W-1:0] prod;
    logic [ACC_W-1:0] total;
    logic [ACC_W-1:0] acc_reg;

    assign prod  = w_reg * rdata;
    assign total = acc_reg + prod;

    always_ff @(posedge clk)
    begin
        if (ctrl.acc_load)
            acc_reg <= prod;
        else if (ctrl.acc_add)
            acc_reg <= total;
    end

    // destination raster position
    logic [DST_DIM_W-1:0] col_inc;
    logic [DST_DIM_W-1:0] row_inc;
    logic [DST_DIM_W-1:0] col_next;
    logic [DST_DIM_W-1:0] row_next;
    logic                 last_next;

    assign col_inc = DST_DIM_W'(emit_col_reg) + 1'b1;
    assign row_inc = DST_DIM_W'(emit_row_reg) + 1'b1;

    always_comb
    begin
        col_next  = col_inc;
        row_next  = DST_DIM_W'(emit_row_reg);
        last_next = 1'b0;
        if (col_inc >= dw)
        begin
            col_next = '0;
            row_next = row_inc;
            if (row_inc >= dh)
            begin
                row_next  = '0;
                last_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            emit_col_reg <= '0;
            emit_row_reg <= '0;
            done         <= 1'b0;
        end
        else
        begin
            done <= ctrl.fin;
            if (ctrl.fin)
            begin
                emit_col_reg <= col_next[COORD_W-1:0];
                emit_row_reg <= row_next[COORD_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.fin)
        begin
            value      <= total[2*FRAC_BITS +: PIX_W];
            out_col    <= emit_col_reg;
            out_row    <= emit_row_reg;
            last_pixel <= last_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/image_bilinear_scaler_top.sv
// top level of the bilinear image scaler
//
// Commands arrive on start/command/pixel and are taken at a clock edge with
// start high and busy low. A load command writes pixel into the source
// store at the next raster position in that same cycle; busy stays low, so
// loads can follow every cycle. An emit command raises busy while it steps
// through its states, and done rises as busy falls: done is high for one
// cycle with value, out_col, out_row and last_pixel. No new command is taken
// before an emit has passed through the transfer, position and address
// arithmetic (ST_POS, ST_LOC), four reads through the single port of the pixel
// store (ST_RD0 to ST_RD3), and the closing of the weighted sum (ST_FIN).
// Registers are written through cfg_we/cfg_index/cfg_data with no wait; the
// user writes them only while no emit is in flight: the block does not enforce it.
// Reset clears the load and emit positions and restores register defaults;
// the store contents are not cleared and must be loaded before use.
// The receiver cannot stall: every result is presented for a single cycle.
`default_nettype none

module image_bilinear_scaler_top #(
    parameter int MAX_SRC_WIDTH  = ibs_pkg::MAX_SRC_WIDTH_DEF,
    parameter int MAX_SRC_HEIGHT = ibs_pkg::MAX_SRC_HEIGHT_DEF,
    parameter int MAX_DST_DIM    = ibs_pkg::MAX_DST_DIM_DEF,
    parameter int FRAC_BITS      = ibs_pkg::FRAC_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic                            command,
    input  wire logic [ibs_pkg::PIX_W-1:0]       pixel,
    output logic                                 busy,
    output logic                                 done,
    output logic      [ibs_pkg::PIX_W-1:0]       value,
    output logic      [ibs_pkg::COORD_W-1:0]     out_col,
    output logic      [ibs_pkg::COORD_W-1:0]     out_row,
    output logic                                 last_pixel,
    input  wire logic                            cfg_we,
    input  wire logic [ibs_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [ibs_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import ibs_pkg::*;

    ibs_ctrl_t ctrl;

    ibs_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (command),
        .busy    (busy),
        .ctrl    (ctrl)
    );

    ibs_datapath #(
        .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
        .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT),
        .MAX_DST_DIM    (MAX_DST_DIM),
        .FRAC_BITS      (FRAC_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .pixel      (pixel),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .done       (done),
        .value      (value),
        .out_col    (out_col),
        .out_row    (out_row),
        .last_pixel (last_pixel)
    );

endmodule

`default_nettype wire

>>> hdl/ibs_checker.sv
// port-level checks of the scaler and their binding to the top level
`default_nettype none

module ibs_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic command,
    input wire logic busy,
    input wire logic done
);

    import ibs_pkg::*;

    // every emit transfer yields its result
    a_emit_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && command == CMD_EMIT) |-> ##8 done)
        else $error("emit result missing");

    // a load never produces a result
    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && command == CMD_LOAD) |=> !done)
        else $error("result after load");

    // busy only rises after an emit transfer
    a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start && command == CMD_EMIT))
        else $error("busy without emit");

    // a result is shown once the block is free again, and not in consecutive cycles
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!busy && !$past(done)))
        else $error("result while busy or repeated");

endmodule

bind image_bilinear_scaler_top ibs_checker u_ibs_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .command (command),
    .busy    (busy),
    .done    (done)
);

`default_nettype wire

>>> sim/image_bilinear_scaler_checker.sv
// checker for the bilinear image scaler: predicts each scaled pixel and compares the results
`timescale 1ns / 100ps

module image_bilinear_scaler_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic                            busy,
    input  logic                            command,
    input  logic [ibs_pkg::PIX_W-1:0]       pixel,
    input  logic                            done,
    input  logic [ibs_pkg::PIX_W-1:0]       value,
    input  logic [ibs_pkg::COORD_W-1:0]     out_col,
    input  logic [ibs_pkg::COORD_W-1:0]     out_row,
    input  logic                            last_pixel,
    input  logic                            cfg_we,
    input  logic [ibs_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ibs_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                              fail_count,
    output int                              open_count,
    output int                              pixel_count
);

    import ibs_pkg::*;

    localparam int STORE_SIZE = MAX_SRC_WIDTH_DEF * MAX_SRC_HEIGHT_DEF;
    localparam int WEIGHT_ONE = 1 << FRAC_BITS_DEF;

    typedef struct packed {
        logic [PIX_W-1:0]   value;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic               last;
    } scaled_px_t;

    bit [PIX_W-1:0]        src_img [0:STORE_SIZE-1];
    int unsigned           load_pos;
    int unsigned           col_pos;
    int unsigned           row_pos;
    logic [SRC_DIM_W-1:0]  src_w_reg;
    logic [SRC_DIM_W-1:0]  src_h_reg;
    logic [DST_DIM_W-1:0]  dst_w_reg;
    logic [DST_DIM_W-1:0]  dst_h_reg;
    logic [STEP_W-1:0]     x_step_reg;
    logic [STEP_W-1:0]     y_step_reg;
    scaled_px_t            pending_pixels [$];

    function automatic int unsigned eff_dim(input int unsigned v, input int unsigned maxv);
        if (v == 0)
            return 1;
        return (v > maxv) ? maxv : v;
    endfunction

    // neighbour pair and fractional weight along one axis
    function automatic void axis_taps(input int unsigned idx, input int unsigned step,
                                      input int unsigned size, output int unsigned p0,
                                      output int unsigned p1, output int unsigned w);
        longint unsigned pos;
        longint unsigned ip;
        pos = 64'(idx);
        pos = pos * 64'(step);
        ip  = pos >> STEP_FRAC;
        w   = 32'((pos >> (STEP_FRAC - FRAC_BITS_DEF)) & 64'(WEIGHT_ONE - 1));
        p0  = (ip > 64'(size - 1)) ? size - 1 : 32'(ip);
        p1  = (ip + 1 > 64'(size - 1)) ? size - 1 : 32'(ip + 1);
    endfunction

    function automatic void check_field(input string name, input int unsigned exp_v,
                                        input int unsigned got_v);
        if (exp_v != got_v)
        begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, exp_v, got_v);
            fail_count++;
        end
    endfunction

    task automatic store_pixel();
        int unsigned span;
        span = eff_dim(32'(src_w_reg), MAX_SRC_WIDTH_DEF)
             * eff_dim(32'(src_h_reg), MAX_SRC_HEIGHT_DEF);
        if (load_pos < STORE_SIZE)
            src_img[load_pos] = pixel;
        load_pos++;
        if (load_pos >= span)
            load_pos = 0;
    endtask

    task automatic predict_scaled();
        int unsigned     sw, sh, dw, dh;
        int unsigned     x0, x1, fx, y0, y1, fy;
        int unsigned     nc, nr;
        longint unsigned wx0, wy0, sum;
        scaled_px_t      px;
        sw = eff_dim(32'(src_w_reg), MAX_SRC_WIDTH_DEF);
        sh = eff_dim(32'(src_h_reg), MAX_SRC_HEIGHT_DEF);
        dw = eff_dim(32'(dst_w_reg), MAX_DST_DIM_DEF);
        dh = eff_dim(32'(dst_h_reg), MAX_DST_DIM_DEF);
        axis_taps(col_pos, 32'(x_step_reg), sw, x0, x1, fx);
        axis_taps(row_pos, 32'(y_step_reg), sh, y0, y1, fy);
        wx0 = WEIGHT_ONE - fx;
        wy0 = WEIGHT_ONE - fy;
        sum = wx0 * wy0 * src_img[y0 * sw + x0]
            + longint'(fx) * wy0 * src_img[y0 * sw + x1]
            + wx0 * longint'(fy) * src_img[y1 * sw + x0]
            + longint'(fx) * longint'(fy) * src_img[y1 * sw + x1];
        px.value = PIX_W'(sum >> (2 * FRAC_BITS_DEF));
        px.col   = col_pos[COORD_W-1:0];
        px.row   = row_pos[COORD_W-1:0];
        px.last  = 1'b0;
        nc = col_pos + 1;
        nr = row_pos;
        if (nc >= dw)
        begin
            nc = 0;
            nr++;
            if (nr >= dh)
            begin
                nr      = 0;
                px.last = 1'b1;
            end
        end
        col_pos = nc & 32'h3FF;
        row_pos = nr & 32'h3FF;
        pending_pixels.push_back(px);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        scaled_px_t want;
        if (!rst_n)
        begin
            load_pos    = 0;
            col_pos     = 0;
            row_pos     = 0;
            src_w_reg   = SRC_DIM_RESET;
            src_h_reg   = SRC_DIM_RESET;
            dst_w_reg   = DST_DIM_RESET;
            dst_h_reg   = DST_DIM_RESET;
            x_step_reg  = STEP_RESET;
            y_step_reg  = STEP_RESET;
            fail_count  = 0;
            pixel_count = 0;
            pending_pixels.delete();
        end
        else
        begin
            if (done)
            begin
                pixel_count++;
                if (pending_pixels.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none, got value %0d at (%0d,%0d)",
                             $time, value, out_col, out_row);
                    fail_count++;
                end
                else
                begin
                    want = pending_pixels.pop_front();
                    check_field("value", 32'(want.value), 32'(value));
                    check_field("out_col", 32'(want.col), 32'(out_col));
                    check_field("out_row", 32'(want.row), 32'(out_row));
                    check_field("last_pixel", 32'(want.last), 32'(last_pixel));
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_SRC_WIDTH:  src_w_reg  = cfg_data[SRC_DIM_W-1:0];
                    REG_SRC_HEIGHT: src_h_reg  = cfg_data[SRC_DIM_W-1:0];
                    REG_DST_WIDTH:  dst_w_reg  = cfg_data[DST_DIM_W-1:0];
                    REG_DST_HEIGHT: dst_h_reg  = cfg_data[DST_DIM_W-1:0];
                    REG_X_STEP:     x_step_reg = cfg_data[STEP_W-1:0];
                    REG_Y_STEP:     y_step_reg = cfg_data[STEP_W-1:0];
                    default: ;
                endcase
            end
            if (start && !busy)
            begin
                if (command == CMD_LOAD)
                    store_pixel();
                else
                    predict_scaled();
            end
        end
        open_count = pending_pixels.size();
    end

endmodule

>>> sim/image_bilinear_scaler_top_tb.sv
// testbench top for the bilinear image scaler: stimulus, scaling set-ups and verdict
`timescale 1ns / 100ps

module image_bilinear_scaler_top_tb;

    import ibs_pkg::*;

    localparam int STORE_SIZE = MAX_SRC_WIDTH_DEF * MAX_SRC_HEIGHT_DEF;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   start     = 1'b0;
    logic                   command   = CMD_LOAD;
    logic [PIX_W-1:0]       pixel     = '0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_SRC_WIDTH;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   busy;
    logic                   done;
    logic [PIX_W-1:0]       value;
    logic [COORD_W-1:0]     out_col;
    logic [COORD_W-1:0]     out_row;
    logic                   last_pixel;
    int                     fail_count;
    int                     open_count;
    int                     pixel_count;

    // stimulus bookkeeping, so that no emit reads a store entry never loaded
    bit                     loaded [0:STORE_SIZE-1];
    int unsigned            fill_pos    = 0;
    int unsigned            store_span  = STORE_SIZE;
    int                     setup_count = 0;
    bit                     no_gaps     = 1'b0;

    always #1 clk = ~clk;

    image_bilinear_scaler_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .command    (command),
        .pixel      (pixel),
        .busy       (busy),
        .done       (done),
        .value      (value),
        .out_col    (out_col),
        .out_row    (out_row),
        .last_pixel (last_pixel),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    image_bilinear_scaler_checker px_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .command     (command),
        .pixel       (pixel),
        .done        (done),
        .value       (value),
        .out_col     (out_col),
        .out_row     (out_row),
        .last_pixel  (last_pixel),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .open_count  (open_count),
        .pixel_count (pixel_count)
    );

    task automatic send_cmd(input logic cmd, input logic [PIX_W-1:0] pix);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 6);
        repeat (gap)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start   <= 1'b1;
        command <= cmd;
        pixel   <= pix;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (cmd == CMD_LOAD)
        begin
            loaded[fill_pos] = 1'b1;
            fill_pos++;
            if (fill_pos >= store_span)
                fill_pos = 0;
        end
    endtask

    task automatic wait_idle();
        @(negedge clk);
        start <= 1'b0;
        while (open_count != 0)
            @(posedge clk);
        repeat (12)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int unsigned data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data[CFG_DATA_W-1:0];
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_scaling(input int unsigned sw, input int unsigned sh,
                               input int unsigned dw, input int unsigned dh,
                               input int unsigned xs, input int unsigned ys);
        int unsigned ew, eh;
        wait_idle();
        write_reg(REG_SRC_WIDTH, sw);
        write_reg(REG_SRC_HEIGHT, sh);
        write_reg(REG_DST_WIDTH, dw);
        write_reg(REG_DST_HEIGHT, dh);
        write_reg(REG_X_STEP, xs);
        write_reg(REG_Y_STEP, ys);
        ew = (sw == 0) ? 1 : ((sw > MAX_SRC_WIDTH_DEF) ? MAX_SRC_WIDTH_DEF : sw);
        eh = (sh == 0) ? 1 : ((sh > MAX_SRC_HEIGHT_DEF) ? MAX_SRC_HEIGHT_DEF : sh);
        store_span = ew * eh;
        setup_count++;
    endtask

    task automatic fill_store(input int unsigned need);
        for (int unsigned k = 0; k < need; k++)
            while (!loaded[k])
                send_cmd(CMD_LOAD, PIX_W'($urandom_range(0, 255)));
    endtask

    task automatic random_items(input int n);
        for (int i = 0; i < n; i++)
        begin
            if (i % 16 == 0)
                no_gaps = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 39) == 0)
                wait_idle();
            if ($urandom_range(0, 99) < 60)
                send_cmd(CMD_EMIT, PIX_W'($urandom_range(0, 255)));
            else
                send_cmd(CMD_LOAD, PIX_W'($urandom_range(0, 255)));
        end
    endtask

    function automatic int unsigned pick_step(input int unsigned src, input int unsigned dst);
        case ($urandom_range(0, 7))
            0, 1, 2: return (src << STEP_FRAC) / dst;
            3, 4:    return $urandom_range(0, 24'hFFFFFF);
            5, 6:    return $urandom_range(1, 24'h030000);
            default: return 0;
        endcase
    endfunction

    initial
    begin
        int unsigned sw, sh, dw, dh;
        repeat (8)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // 2x2 source, fractional steps, right and bottom edge clamps, wraps
        set_scaling(2, 2, 3, 2, 24'h00C000, 24'h018000);
        send_cmd(CMD_LOAD, 8'h00);
        send_cmd(CMD_LOAD, 8'hFF);
        send_cmd(CMD_LOAD, 8'hA5);
        send_cmd(CMD_LOAD, 8'h5A);
        repeat (7)
            send_cmd(CMD_EMIT, PIX_W'($urandom_range(0, 255)));
        send_cmd(CMD_LOAD, 8'hFF);
        send_cmd(CMD_EMIT, 8'h00);

        // position far beyond the image and a zero step
        set_scaling(2, 2, 2, 3, 24'hFFFFFF, 0);
        repeat (4)
            send_cmd(CMD_EMIT, 8'hFF);

        // single pixel source and destination, leftover position wraps
        set_scaling(1, 1, 1, 1, 0, 24'hFFFFFF);
        send_cmd(CMD_LOAD, 8'h3C);
        send_cmd(CMD_LOAD, 8'hC3);
        repeat (3)
            send_cmd(CMD_EMIT, PIX_W'($urandom_range(0, 255)));

        // largest source and destination width, rows 0 and 1 only
        set_scaling(MAX_SRC_WIDTH_DEF, MAX_SRC_HEIGHT_DEF, MAX_DST_DIM_DEF, 2,
                    24'h050000, 1);
        fill_store(2 * MAX_SRC_WIDTH_DEF);
        random_items(60);

        // out-of-range sizes: zero and above the maximum
        set_scaling(511, 0, 0, 2047, pick_step(256, 4), pick_step(1, 3));
        fill_store(store_span);
        random_items(60);

        repeat (10)
        begin
            sw = $urandom_range(1, 12);
            sh = $urandom_range(1, 12);
            dw = $urandom_range(1, 8);
            dh = $urandom_range(1, 8);
            set_scaling(sw, sh, dw, dh, pick_step(sw, dw), pick_step(sh, dh));
            fill_store(store_span);
            random_items(60);
        end

        no_gaps = 1'b0;
        wait_idle();
        $display("%0d scaled pixels checked over %0d scaling set-ups", pixel_count, setup_count);
        $display("covering edge clamps, zero and maximum steps, out-of-range sizes and wraps");
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
